// ===== rtl/frame_point_transform_3d_defines.svh =====
// ----------------------------------------------------------------------------
// frame_point_transform_3d assertion macros
// Shared property macros for the frame transform pipeline; they compile away
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FRAME_POINT_TRANSFORM_3D_DEFINES_SVH
`define FRAME_POINT_TRANSFORM_3D_DEFINES_SVH

`ifndef SYNTH
`define FPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FPT_ASSERT_NOW(lbl, ante, cons)
`define FPT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/fpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpt_pkg
// Opcodes, register indexes and stage control shared by the frame transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpt_pkg;

  localparam int CFG_IDX_W   = 8;
  localparam int INNER_GUARD = 4;

  typedef enum logic [2:0] {
    OP_FULL,
    OP_ROT,
    OP_DISP,
    OP_FULL_INV,
    OP_ROT_INV,
    OP_DISP_INV
  } fpt_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN,
    REG_X_AXIS,
    REG_Y_AXIS,
    REG_Z_AXIS,
    REG_ROT_ROW_0,
    REG_ROT_ROW_1,
    REG_ROT_ROW_2,
    REG_DISPLACEMENT
  } fpt_reg_e;

  typedef struct packed {
    logic use_a;
    logic add_en;
    logic sub;
  } fpt_ofs_ctrl_t;

  function automatic logic fpt_pre_sub(logic [2:0] op);
    case (op) inside
      OP_FULL_INV, OP_DISP_INV: return 1'b1;
      default:                  return 1'b0;
    endcase
  endfunction

  function automatic logic fpt_rotates(logic [2:0] op);
    case (op) inside
      OP_FULL, OP_ROT, OP_FULL_INV, OP_ROT_INV: return 1'b1;
      default:                                  return 1'b0;
    endcase
  endfunction

  function automatic logic fpt_post_add(logic [2:0] op);
    case (op) inside
      OP_FULL, OP_DISP: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic fpt_inverse(logic [2:0] op);
    case (op) inside
      OP_FULL_INV, OP_ROT_INV, OP_DISP_INV: return 1'b1;
      default:                              return 1'b0;
    endcase
  endfunction

  function automatic logic fpt_pass(logic [2:0] op);
    case (op) inside
      OP_FULL, OP_ROT, OP_DISP, OP_FULL_INV, OP_ROT_INV, OP_DISP_INV: return 1'b0;
      default:                                                        return 1'b1;
    endcase
  endfunction

endpackage

// ===== rtl/fpt_matvec.sv =====
// ----------------------------------------------------------------------------
// fpt_matvec
// Two-stage 3x3 matrix times vector: nine registered products, then three
// sums rounded half up by FRAC bits. A sideband word rides along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_point_transform_3d_defines.svh"

module fpt_matvec
  import fpt_pkg::*;
#(
  parameter int A_W  = 22,
  parameter int B_W  = 21,
  parameter int FRAC = 19,
  parameter int SB_W = 1,
  localparam int P_W = A_W + B_W,
  localparam int R_W = A_W + B_W + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [A_W-1:0] vec [3],
  input  logic signed [B_W-1:0] mat [3][3],
  input  logic [SB_W-1:0]       sb_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [R_W-1:0] res [3],
  output logic [SB_W-1:0]       sb_out
);

  localparam logic signed [R_W-1:0] RND = R_W'(1) << (FRAC - 1);

  logic                  v1;
  logic                  rdy1;
  logic                  rdy2;
  logic signed [P_W-1:0] prod [3][3];
  logic [SB_W-1:0]       sb1;
  logic signed [R_W-1:0] sum [3];

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= vec[j] * mat[i][j];
        end
      end
      sb1 <= sb_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = R_W'(prod[i][0]) + R_W'(prod[i][1]) + R_W'(prod[i][2]) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int i = 0; i < 3; i++) begin
        res[i] <= sum[i] >>> FRAC;
      end
      sb_out <= sb1;
    end
  end

  `FPT_ASSERT_NEXT(a_mv_load, in_valid && in_ready, v1)
  `FPT_ASSERT_NEXT(a_mv_hold, v1 && !rdy2, v1)
  `FPT_ASSERT_NEXT(a_mv_move, v1 && rdy2, out_valid)

endmodule

// ===== rtl/fpt_offset_stage.sv =====
// ----------------------------------------------------------------------------
// fpt_offset_stage
// One register stage: pick the rounded product (clamped if PRE_CLAMP) or a
// bypass vector, add or subtract the offset if enabled, clamp, flag any clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_point_transform_3d_defines.svh"

module fpt_offset_stage
  import fpt_pkg::*;
#(
  parameter int IW        = 46,
  parameter int BW        = 25,
  parameter int OFW       = 21,
  parameter int OW        = 25,
  parameter bit PRE_CLAMP = 1'b1,
  parameter int SB_W      = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fpt_ofs_ctrl_t         ctrl,
  input  logic signed [IW-1:0]  a [3],
  input  logic signed [BW-1:0]  b [3],
  input  logic signed [OFW-1:0] ofs [3],
  input  logic [SB_W-1:0]       sb_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [OW-1:0]  res [3],
  output logic                  flag,
  output logic [SB_W-1:0]       sb_out
);

  localparam int SW = IW + 1;
  localparam logic signed [IW-1:0] A_HI = $signed({{(IW-OW+1){1'b0}}, {(OW-1){1'b1}}});
  localparam logic signed [IW-1:0] A_LO = ~A_HI;
  localparam logic signed [SW-1:0] Y_HI = $signed({{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}});
  localparam logic signed [SW-1:0] Y_LO = ~Y_HI;

  logic signed [IW-1:0] x [3];
  logic signed [SW-1:0] y [3];
  logic signed [OW-1:0] z [3];
  logic                 flag_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    flag_next = 1'b0;
    for (int j = 0; j < 3; j++) begin
      x[j] = IW'(b[j]);
      if (ctrl.use_a) begin
        if (PRE_CLAMP && (a[j] > A_HI)) begin
          x[j] = A_HI;
          flag_next = 1'b1;
        end else if (PRE_CLAMP && (a[j] < A_LO)) begin
          x[j] = A_LO;
          flag_next = 1'b1;
        end else begin
          x[j] = a[j];
        end
      end
      y[j] = SW'(x[j]);
      if (ctrl.add_en) begin
        y[j] = ctrl.sub ? (y[j] - SW'(ofs[j])) : (y[j] + SW'(ofs[j]));
      end
      if (y[j] > Y_HI) begin
        z[j] = OW'(Y_HI);
        flag_next = 1'b1;
      end else if (y[j] < Y_LO) begin
        z[j] = OW'(Y_LO);
        flag_next = 1'b1;
      end else begin
        z[j] = OW'(y[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res    <= z;
      flag   <= flag_next;
      sb_out <= sb_in;
    end
  end

  `FPT_ASSERT_NEXT(a_os_load, in_valid && in_ready, out_valid)
  `FPT_ASSERT_NOW(a_os_room, !out_valid, in_ready)
  `FPT_ASSERT_NEXT(a_os_quiet, in_valid && in_ready && !ctrl.use_a && !ctrl.add_en, !flag)

endmodule

// ===== rtl/frame_point_transform_3d.sv =====
// ----------------------------------------------------------------------------
// frame_point_transform_3d
// Maps a point into a loaded local frame, applies rotation and/or
// displacement or their inverses, and maps it back to global coordinates.
// ----------------------------------------------------------------------------
// Accepts one point per clock while the output side does not stall and
// returns one result per point, in order. The pipeline is an input
// register that subtracts the origin, three matrix units of two stages
// each (products, then rounded sums) and three offset/clamp stages.
// Every stage holds its own valid bit, so a stalled output only blocks
// the input once the stages behind it are all full.
// Registers are written through cfg_wen/cfg_index/cfg_data; indexes past
// the displacement register are ignored. Positions carry any fixed fraction;
// axis and matrix entries carry UNIT_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_point_transform_3d
  import fpt_pkg::*;
#(
  parameter int COMP_WIDTH     = 21,
  parameter int UNIT_FRAC_BITS = 19
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [3*COMP_WIDTH-1:0]       cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    opcode,
  input  logic signed [COMP_WIDTH-1:0]  in_x,
  input  logic signed [COMP_WIDTH-1:0]  in_y,
  input  logic signed [COMP_WIDTH-1:0]  in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COMP_WIDTH-1:0]  out_x,
  output logic signed [COMP_WIDTH-1:0]  out_y,
  output logic signed [COMP_WIDTH-1:0]  out_z,
  output logic                          saturated
);

  localparam int CW      = COMP_WIDTH;
  localparam int REG_W   = 3 * CW;
  localparam int INNER_W = CW + INNER_GUARD;
  localparam int D_W     = CW + 1;
  localparam int R1_W    = D_W + CW + 2;
  localparam int R2_W    = INNER_W + CW + 2;

  localparam logic [REG_W-1:0] UNIT_0 = REG_W'(1) << UNIT_FRAC_BITS;
  localparam logic [REG_W-1:0] UNIT_1 = REG_W'(1) << (UNIT_FRAC_BITS + CW);
  localparam logic [REG_W-1:0] UNIT_2 = REG_W'(1) << (UNIT_FRAC_BITS + 2 * CW);

  typedef struct packed {
    logic [2:0][CW-1:0]      p;
    logic [2:0][INNER_W-1:0] loc;
    logic                    sat;
    logic [2:0]              op;
  } sb_t;

  localparam int SB_W = $bits(sb_t);

  logic [2:0][CW-1:0] origin;
  logic [2:0][CW-1:0] axis [3];
  logic [2:0][CW-1:0] rot [3];
  logic [2:0][CW-1:0] displacement;

  logic signed [CW-1:0] org_s [3];
  logic signed [CW-1:0] disp_s [3];
  logic signed [CW-1:0] axis_s [3][3];
  logic signed [CW-1:0] axis_t [3][3];
  logic signed [CW-1:0] rot_sel [3][3];
  logic signed [CW-1:0] p_in [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin       <= '0;
      axis[0]      <= UNIT_0;
      axis[1]      <= UNIT_1;
      axis[2]      <= UNIT_2;
      rot[0]       <= UNIT_0;
      rot[1]       <= UNIT_1;
      rot[2]       <= UNIT_2;
      displacement <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_ORIGIN:       origin       <= cfg_data;
        REG_X_AXIS:       axis[0]      <= cfg_data;
        REG_Y_AXIS:       axis[1]      <= cfg_data;
        REG_Z_AXIS:       axis[2]      <= cfg_data;
        REG_ROT_ROW_0:    rot[0]       <= cfg_data;
        REG_ROT_ROW_1:    rot[1]       <= cfg_data;
        REG_ROT_ROW_2:    rot[2]       <= cfg_data;
        REG_DISPLACEMENT: displacement <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: point minus origin
  logic            v0;
  logic            mv1_ready;
  logic signed [D_W-1:0] d0 [3];
  sb_t             sb0;

  assign p_in[0]  = in_x;
  assign p_in[1]  = in_y;
  assign p_in[2]  = in_z;
  assign in_ready = !v0 || mv1_ready;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      org_s[j]  = $signed(origin[j]);
      disp_s[j] = $signed(displacement[j]);
      for (int i = 0; i < 3; i++) begin
        axis_s[i][j] = $signed(axis[i][j]);
        axis_t[j][i] = $signed(axis[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ready) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int j = 0; j < 3; j++) begin
        d0[j] <= D_W'(p_in[j]) - D_W'(org_s[j]);
      end
      sb0.p   <= {in_z, in_y, in_x};
      sb0.loc <= '0;
      sb0.sat <= 1'b0;
      sb0.op  <= opcode;
    end
  end

  // global to local
  logic                   v1, osa_ready;
  logic signed [R1_W-1:0] r1 [3];
  sb_t                    sb1;

  fpt_matvec #(
    .A_W (D_W),
    .B_W (CW),
    .FRAC(UNIT_FRAC_BITS),
    .SB_W(SB_W)
  ) u_mv_local (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v0),
    .in_ready (mv1_ready),
    .vec      (d0),
    .mat      (axis_s),
    .sb_in    (sb0),
    .out_valid(v1),
    .out_ready(osa_ready),
    .res      (r1),
    .sb_out   (sb1)
  );

  // clamp, subtract displacement on OP_FULL_INV and OP_DISP_INV
  fpt_ofs_ctrl_t             ctrl_a;
  logic                      va, mv2_ready, flag_a;
  logic signed [INNER_W-1:0] zero_vec [3];
  logic signed [INNER_W-1:0] loc_a [3];
  sb_t                       sba;

  assign zero_vec = '{default: '0};
  assign ctrl_a   = '{use_a: 1'b1, add_en: fpt_pre_sub(sb1.op), sub: 1'b1};

  fpt_offset_stage #(
    .IW       (R1_W),
    .BW       (INNER_W),
    .OFW      (CW),
    .OW       (INNER_W),
    .PRE_CLAMP(1'b1),
    .SB_W     (SB_W)
  ) u_os_pre (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .in_ready (osa_ready),
    .ctrl     (ctrl_a),
    .a        (r1),
    .b        (zero_vec),
    .ofs      (disp_s),
    .sb_in    (sb1),
    .out_valid(va),
    .out_ready(mv2_ready),
    .res      (loc_a),
    .flag     (flag_a),
    .sb_out   (sba)
  );

  // rotation, transposed on inverse ops
  sb_t                    sb2_in, sb2;
  logic                   v2, osb_ready;
  logic signed [R2_W-1:0] r2 [3];
  logic                   inv_a;

  assign inv_a = fpt_inverse(sba.op);

  always_comb begin
    sb2_in     = sba;
    sb2_in.sat = sba.sat | flag_a;
    for (int i = 0; i < 3; i++) begin
      sb2_in.loc[i] = loc_a[i];
      for (int j = 0; j < 3; j++) begin
        rot_sel[i][j] = inv_a ? $signed(rot[j][i]) : $signed(rot[i][j]);
      end
    end
  end

  fpt_matvec #(
    .A_W (INNER_W),
    .B_W (CW),
    .FRAC(UNIT_FRAC_BITS),
    .SB_W(SB_W)
  ) u_mv_rot (
    .clk      (clk),
    .rst      (rst),
    .in_valid (va),
    .in_ready (mv2_ready),
    .vec      (loc_a),
    .mat      (rot_sel),
    .sb_in    (sb2_in),
    .out_valid(v2),
    .out_ready(osb_ready),
    .res      (r2),
    .sb_out   (sb2)
  );

  // select rotated or bypass, add displacement on OP_FULL and OP_DISP
  fpt_ofs_ctrl_t             ctrl_b;
  logic                      vb, mv3_ready, flag_b;
  logic signed [INNER_W-1:0] loc_bypass [3];
  logic signed [INNER_W-1:0] loc_b [3];
  sb_t                       sbb;

  assign ctrl_b = '{use_a: fpt_rotates(sb2.op), add_en: fpt_post_add(sb2.op), sub: 1'b0};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      loc_bypass[j] = $signed(sb2.loc[j]);
    end
  end

  fpt_offset_stage #(
    .IW       (R2_W),
    .BW       (INNER_W),
    .OFW      (CW),
    .OW       (INNER_W),
    .PRE_CLAMP(1'b1),
    .SB_W     (SB_W)
  ) u_os_post (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .in_ready (osb_ready),
    .ctrl     (ctrl_b),
    .a        (r2),
    .b        (loc_bypass),
    .ofs      (disp_s),
    .sb_in    (sb2),
    .out_valid(vb),
    .out_ready(mv3_ready),
    .res      (loc_b),
    .flag     (flag_b),
    .sb_out   (sbb)
  );

  // local to global
  sb_t                    sb3_in, sb3;
  logic                   v3, osc_ready;
  logic signed [R2_W-1:0] r3 [3];

  always_comb begin
    sb3_in     = sbb;
    sb3_in.sat = sbb.sat | flag_b;
  end

  fpt_matvec #(
    .A_W (INNER_W),
    .B_W (CW),
    .FRAC(UNIT_FRAC_BITS),
    .SB_W(SB_W)
  ) u_mv_global (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vb),
    .in_ready (mv3_ready),
    .vec      (loc_b),
    .mat      (axis_t),
    .sb_in    (sb3_in),
    .out_valid(v3),
    .out_ready(osc_ready),
    .res      (r3),
    .sb_out   (sb3)
  );

  // add origin and clamp; unused opcodes pass the point through
  fpt_ofs_ctrl_t        ctrl_c;
  logic                 pass3, flag_c;
  logic signed [CW-1:0] p3 [3];
  logic signed [CW-1:0] res_c [3];
  sb_t                  sbc;

  assign pass3  = fpt_pass(sb3.op);
  assign ctrl_c = '{use_a: !pass3, add_en: !pass3, sub: 1'b0};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p3[j] = $signed(sb3.p[j]);
    end
  end

  fpt_offset_stage #(
    .IW       (R2_W),
    .BW       (CW),
    .OFW      (CW),
    .OW       (CW),
    .PRE_CLAMP(1'b0),
    .SB_W     (SB_W)
  ) u_os_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_ready (osc_ready),
    .ctrl     (ctrl_c),
    .a        (r3),
    .b        (p3),
    .ofs      (org_s),
    .sb_in    (sb3),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res_c),
    .flag     (flag_c),
    .sb_out   (sbc)
  );

  assign out_x     = res_c[0];
  assign out_y     = res_c[1];
  assign out_z     = res_c[2];
  assign saturated = (sbc.sat | flag_c) & !fpt_pass(sbc.op);

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: frame_point_transform_3d testbench
// Streams points through the frame transform under several register settings
// and checks every result, in order, against a fixed-point predictor of the
// frame mapping, rotation, displacement and saturation behavior. In most phases
// both sides of the stream idle at random; registers change only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import fpt_pkg::*;
();

  localparam int CW          = 21;
  localparam int UF          = 19;
  localparam int IW          = CW + INNER_GUARD;
  localparam int REG_COUNT   = 8;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int MAX_PRINTS  = 100;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic [CW-1:0] POS_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] POS_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] UNIT_ONE = CW'(1) << UF;
  localparam logic [CW-1:0] NEG_UNIT = -UNIT_ONE;

  typedef enum {FRAME_NEAR_UNIT, FRAME_AXIS_ALIGNED, FRAME_RAW, FRAME_EXTREME} frame_mode_e;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 sat;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [3*CW-1:0]      cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           opcode = '0;
  logic signed [CW-1:0] in_x = '0;
  logic signed [CW-1:0] in_y = '0;
  logic signed [CW-1:0] in_z = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic                 saturated;

  logic [3*CW-1:0] frame_regs [REG_COUNT];
  logic [3*CW-1:0] next_frame [REG_COUNT];
  point_t          pending_q [$];
  outcome_t        expected_q [$];
  bit              idle_en = 1'b1;
  bit              in_taken = 1'b0;
  int              send_gap = 0;
  int              stall_left = 0;
  int              errors = 0;

  frame_point_transform_3d DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated)
  );

  always #5 clk = ~clk;

  function automatic logic [3*CW-1:0] pack3(logic [CW-1:0] a, logic [CW-1:0] b,
                                            logic [CW-1:0] c);
    return {c, b, a};
  endfunction

  function automatic logic [3*CW-1:0] axis_row(int k, bit neg);
    logic [3*CW-1:0] v;
    v = {{(2*CW){1'b0}}, neg ? NEG_UNIT : UNIT_ONE};
    return v << (k * CW);
  endfunction

  function automatic logic [CW-1:0] extreme_pick(int k);
    case (k % 6)
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return '0;
      3:       return '1;
      4:       return UNIT_ONE;
      default: return NEG_UNIT;
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_pos();
    int v;
    case ($urandom_range(0, 5))
      0:       return extreme_pick($urandom_range(0, 5));
      1, 2: begin
        v = $urandom;
        return v[CW-1:0];
      end
      default: begin
        v = $urandom_range(0, 8191) - 4096;
        return v[CW-1:0];
      end
    endcase
  endfunction

  function automatic logic [CW-1:0] near_unit();
    int v;
    v = $urandom_range(0, 2 * (1 << UF)) - (1 << UF);
    return v[CW-1:0];
  endfunction

  function automatic point_t random_point();
    point_t pt;
    int     op;
    if ($urandom_range(0, 9) == 0)
      op = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
    else
      op = $urandom_range(OP_FULL, OP_DISP_INV);
    pt.op = op[2:0];
    pt.x  = rand_pos();
    pt.y  = rand_pos();
    pt.z  = rand_pos();
    return pt;
  endfunction

  function automatic longint coef(int r, int k);
    logic signed [CW-1:0] c;
    c = frame_regs[r][k*CW +: CW];
    return longint'(c);
  endfunction

  function automatic longint round_unit(longint v);
    return (v + (longint'(1) << (UF - 1))) >>> UF;
  endfunction

  function automatic longint clamp_to(longint v, int w, inout bit sat);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic outcome_t transform_point(point_t pt);
    outcome_t res;
    longint   pos [3];
    longint   loc [3];
    longint   tmp [3];
    longint   glob [3];
    longint   acc;
    bit       sat;
    bit       inverse;
    sat     = 1'b0;
    inverse = (pt.op >= OP_FULL_INV);
    pos[0]  = longint'($signed(pt.x));
    pos[1]  = longint'($signed(pt.y));
    pos[2]  = longint'($signed(pt.z));
    if (pt.op > OP_DISP_INV) begin
      res.x   = pt.x;
      res.y   = pt.y;
      res.z   = pt.z;
      res.sat = 1'b0;
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += (pos[j] - coef(REG_ORIGIN, j)) * coef(int'(REG_X_AXIS) + i, j);
      loc[i] = clamp_to(round_unit(acc), IW, sat);
    end
    if (pt.op == OP_FULL_INV || pt.op == OP_DISP_INV)
      for (int i = 0; i < 3; i++)
        loc[i] = clamp_to(loc[i] - coef(REG_DISPLACEMENT, i), IW, sat);
    if (pt.op != OP_DISP && pt.op != OP_DISP_INV) begin
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++)
          acc += (inverse ? coef(int'(REG_ROT_ROW_0) + j, i)
                          : coef(int'(REG_ROT_ROW_0) + i, j)) * loc[j];
        tmp[i] = clamp_to(round_unit(acc), IW, sat);
      end
      for (int i = 0; i < 3; i++)
        loc[i] = tmp[i];
    end
    if (pt.op == OP_FULL || pt.op == OP_DISP)
      for (int i = 0; i < 3; i++)
        loc[i] = clamp_to(loc[i] + coef(REG_DISPLACEMENT, i), IW, sat);
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int i = 0; i < 3; i++)
        acc += loc[i] * coef(int'(REG_X_AXIS) + i, j);
      glob[j] = clamp_to(round_unit(acc) + coef(REG_ORIGIN, j), CW, sat);
    end
    res.x   = glob[0][CW-1:0];
    res.y   = glob[1][CW-1:0];
    res.z   = glob[2][CW-1:0];
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic write_reg(int idx, logic [3*CW-1:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data  <= data;
    if (idx < REG_COUNT)
      frame_regs[idx] = data;
  endtask

  task automatic apply_frame(bit stray);
    for (int r = 0; r < REG_COUNT; r++)
      write_reg(r, next_frame[r]);
    if (stray)
      write_reg($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1),
                (3 * CW)'({$urandom, $urandom}));
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic plan_frame(frame_mode_e mode);
    bit is_pos;
    for (int r = 0; r < REG_COUNT; r++) begin
      is_pos = (r == REG_ORIGIN || r == REG_DISPLACEMENT);
      case (mode)
        FRAME_RAW:
          next_frame[r] = (3 * CW)'({$urandom, $urandom});
        FRAME_EXTREME:
          next_frame[r] = pack3(extreme_pick($urandom_range(0, 5)),
                                extreme_pick($urandom_range(0, 5)),
                                extreme_pick($urandom_range(0, 5)));
        FRAME_AXIS_ALIGNED:
          next_frame[r] = is_pos ? pack3(rand_pos(), rand_pos(), rand_pos())
                                 : axis_row($urandom_range(0, 2),
                                            $urandom_range(0, 1) == 1);
        default:
          next_frame[r] = is_pos ? pack3(rand_pos(), rand_pos(), rand_pos())
                                 : pack3(near_unit(), near_unit(), near_unit());
      endcase
    end
  endtask

  task automatic queue_all_ops(int shift);
    int k;
    for (k = OP_FULL; k <= OP_SPARE_HI; k++)
      pending_q.push_back('{k[2:0], extreme_pick(k + shift), extreme_pick(k + shift + 2),
                            extreme_pick(k + shift + 4)});
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(posedge clk);
  endtask

  always @(negedge clk) begin : drive_points
    point_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        in_valid <= 1'b1;
        opcode   <= nxt.op;
        in_x     <= nxt.x;
        in_y     <= nxt.y;
        in_z     <= nxt.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    outcome_t want;
    point_t   taken;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, out_x", longint'(out_x), 0);
        end else begin
          want = expected_q.pop_front();
          if (out_x !== want.x)
            report_mismatch("out_x", longint'(out_x), longint'(want.x));
          if (out_y !== want.y)
            report_mismatch("out_y", longint'(out_y), longint'(want.y));
          if (out_z !== want.z)
            report_mismatch("out_z", longint'(out_z), longint'(want.z));
          if (saturated !== want.sat)
            report_mismatch("saturated", longint'(saturated), longint'(want.sat));
        end
      end
      if (in_taken) begin
        taken = '{opcode, in_x, in_y, in_z};
        expected_q.push_back(transform_point(taken));
      end
    end
  end

  initial begin
    for (int r = 0; r < REG_COUNT; r++)
      frame_regs[r] = '0;
    frame_regs[REG_X_AXIS]    = axis_row(0, 1'b0);
    frame_regs[REG_Y_AXIS]    = axis_row(1, 1'b0);
    frame_regs[REG_Z_AXIS]    = axis_row(2, 1'b0);
    frame_regs[REG_ROT_ROW_0] = axis_row(0, 1'b0);
    frame_regs[REG_ROT_ROW_1] = axis_row(1, 1'b0);
    frame_regs[REG_ROT_ROW_2] = axis_row(2, 1'b0);
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    queue_all_ops(0);
    wait_drained();

    next_frame[REG_ORIGIN]       = pack3(21'sd3072, -21'sd5120, 21'sd100);
    next_frame[REG_X_AXIS]       = axis_row(1, 1'b0);
    next_frame[REG_Y_AXIS]       = axis_row(0, 1'b1);
    next_frame[REG_Z_AXIS]       = axis_row(2, 1'b1);
    next_frame[REG_ROT_ROW_0]    = axis_row(1, 1'b1);
    next_frame[REG_ROT_ROW_1]    = axis_row(0, 1'b0);
    next_frame[REG_ROT_ROW_2]    = axis_row(2, 1'b0);
    next_frame[REG_DISPLACEMENT] = pack3(POS_MAX, POS_MIN, 21'sd12345);
    apply_frame(1'b1);
    queue_all_ops(1);
    wait_drained();

    next_frame[REG_ORIGIN]       = pack3(POS_MIN, POS_MAX, '0);
    next_frame[REG_X_AXIS]       = pack3(POS_MIN, POS_MIN, POS_MIN);
    next_frame[REG_Y_AXIS]       = pack3(POS_MAX, POS_MAX, POS_MAX);
    next_frame[REG_Z_AXIS]       = pack3(POS_MIN, POS_MAX, POS_MIN);
    next_frame[REG_ROT_ROW_0]    = pack3(POS_MAX, POS_MAX, POS_MAX);
    next_frame[REG_ROT_ROW_1]    = pack3(POS_MIN, POS_MIN, POS_MIN);
    next_frame[REG_ROT_ROW_2]    = pack3(POS_MAX, POS_MIN, POS_MAX);
    next_frame[REG_DISPLACEMENT] = pack3(POS_MAX, POS_MAX, POS_MIN);
    apply_frame(1'b0);
    queue_all_ops(3);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_en = (ph < PHASES - 2) && ($urandom_range(0, 4) != 0);
      plan_frame(frame_mode_e'(ph % 4));
      apply_frame($urandom_range(0, 1) == 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_q.push_back(random_point());
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
